>>> hdl/hbridge_channel_pwm_monitor_core_macros.svh
// assertion helpers shared by the monitor core
`ifndef HBRIDGE_CHANNEL_PWM_MONITOR_CORE_MACROS_SVH
`define HBRIDGE_CHANNEL_PWM_MONITOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define HBPM_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hbpm check failed: same-cycle implication");

`define HBPM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hbpm check failed: next-cycle implication");

`else

`define HBPM_ASSERT_IMPLIES(name, clk, rst, ante, cons)

`define HBPM_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

>>> hdl/hbpm_pkg.sv
`timescale 1ns / 1ps

package hbpm_pkg;

   localparam int DRIVE_BITS = 2;
   localparam int DUTY_BITS  = 7;

   typedef logic [DRIVE_BITS-1:0] motion_type;
   typedef logic [DUTY_BITS-1:0]  duty_type;

   // drive state codes
   localparam motion_type DRIVE_BACKWARD = 2'd0;
   localparam motion_type DRIVE_FORWARD  = 2'd1;
   localparam motion_type DRIVE_BRAKE    = 2'd2;
   localparam motion_type DRIVE_FREE     = 2'd3;

   localparam duty_type DUTY_SCALE = 7'd100;

   // result item: motion, duty_percent, duty_changed
   localparam int RSP_FIELD_BITS = DRIVE_BITS + DUTY_BITS + 1;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // per-item command from the front to the back
   typedef struct packed {
      motion_type motion;
      logic       edge_seen;
   } cmd_ctl_type;

endpackage

>>> hdl/hbpm_front.sv
`timescale 1ns / 1ps
`include "hbridge_channel_pwm_monitor_core_macros.svh"

module hbpm_front
   import hbpm_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wen,
   input  logic                 csr_wdata,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [TIME_BITS-1:0] in_time,
   input  logic                 in_enable,
   input  logic                 in_dir_first,
   input  logic                 in_dir_second,
   input  logic                 queue_full,
   output logic                 push,
   output cmd_ctl_type          push_ctl,
   output logic [TIME_BITS-1:0] push_high,
   output logic [TIME_BITS-1:0] push_low
);

   logic                 pwm_mode_ff;
   logic                 last_enable_ff;
   logic [TIME_BITS-1:0] rise_ff;
   logic [TIME_BITS-1:0] fall_ff;
   logic [TIME_BITS-1:0] high_ff;
   logic [TIME_BITS-1:0] low_ff;
   logic [TIME_BITS-1:0] high_in;
   logic [TIME_BITS-1:0] low_in;
   logic                 edge_seen;
   motion_type           motion;

   assign in_ready  = !queue_full;
   assign push      = in_valid && !queue_full;
   assign edge_seen = in_enable != last_enable_ff;

   // spans wrap naturally at the time width
   always_comb begin
      high_in = high_ff;
      low_in  = low_ff;
      if (edge_seen && in_enable) begin
         low_in = in_time - fall_ff;
      end
      if (edge_seen && !in_enable) begin
         high_in = in_time - rise_ff;
      end
   end

   always_comb begin
      if (pwm_mode_ff && !in_enable) begin
         motion = DRIVE_FREE;
      end else if (in_dir_first == in_dir_second) begin
         motion = DRIVE_BRAKE;
      end else if (in_dir_first) begin
         motion = DRIVE_BACKWARD;
      end else begin
         motion = DRIVE_FORWARD;
      end
   end

   assign push_ctl.motion    = motion;
   assign push_ctl.edge_seen = edge_seen;
   assign push_high          = high_in;
   assign push_low           = low_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_mode_ff    <= 1'b1;
         last_enable_ff <= 1'b0;
         rise_ff        <= '0;
         fall_ff        <= '0;
         high_ff        <= '0;
         low_ff         <= '0;
      end else begin
         if (csr_wen) begin
            pwm_mode_ff <= csr_wdata;
         end
         if (push) begin
            last_enable_ff <= in_enable;
            high_ff        <= high_in;
            low_ff         <= low_in;
            if (edge_seen && in_enable) begin
               rise_ff <= in_time;
            end
            if (edge_seen && !in_enable) begin
               fall_ff <= in_time;
            end
         end
      end
   end

   `HBPM_ASSERT_IMPLIES(a_jumper_never_free, clock, reset, push && !pwm_mode_ff, push_ctl.motion != DRIVE_FREE)

endmodule

>>> hdl/hbpm_queue.sv
`timescale 1ns / 1ps
`include "hbridge_channel_pwm_monitor_core_macros.svh"

module hbpm_queue
   import hbpm_pkg::*;
#(
   parameter int DATA_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cmd_ctl_type          push_ctl,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   output logic                 not_empty,
   input  logic                 pop,
   output cmd_ctl_type          pop_ctl,
   output logic [DATA_BITS-1:0] pop_data
);

   localparam int DEPTH      = 2;
   localparam int PTR_BITS   = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   cmd_ctl_type          ctl_ff  [DEPTH];
   logic [DATA_BITS-1:0] data_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff;
   logic [PTR_BITS-1:0]  rd_ptr_ff;
   logic [COUNT_BITS-1:0] count_ff;

   assign full      = count_ff == COUNT_BITS'(DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_ctl   = ctl_ff[rd_ptr_ff];
   assign pop_data  = data_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         ctl_ff[wr_ptr_ff]  <= push_ctl;
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `HBPM_ASSERT_IMPLIES(a_pop_not_empty, clock, reset, pop, not_empty)
   `HBPM_ASSERT_IMPLIES(a_push_not_full, clock, reset, push, !full || pop)
   `HBPM_ASSERT_NEXT(a_count_drains, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1)

endmodule

>>> hdl/hbpm_back.sv
`timescale 1ns / 1ps
`include "hbridge_channel_pwm_monitor_core_macros.svh"

module hbpm_back
   import hbpm_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  cmd_ctl_type          q_ctl,
   input  logic [TIME_BITS-1:0] q_high,
   input  logic [TIME_BITS-1:0] q_low,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output motion_type           rsp_drive,
   output duty_type             rsp_duty,
   output logic                 rsp_changed
);

   localparam int SUM_BITS  = TIME_BITS + 1;
   localparam int REM_BITS  = TIME_BITS + DUTY_BITS;
   localparam int STEP_BITS = $clog2(DUTY_BITS);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DIVIDE = 2'd1;
   localparam logic [1:0] S_EMIT   = 2'd2;

   logic [1:0]           state_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic [REM_BITS-1:0]  rem_ff;
   logic [REM_BITS-1:0]  dvs_ff;
   duty_type             quot_ff;
   duty_type             shown_ff;
   motion_type           drive_ff;
   logic                 rsp_valid_ff;
   motion_type           rsp_drive_ff;
   duty_type             rsp_duty_ff;
   logic                 rsp_changed_ff;

   logic [SUM_BITS-1:0]  sum;
   logic [REM_BITS-1:0]  scaled_high;
   logic [REM_BITS:0]    diff;
   logic                 emit;

   assign sum = {1'b0, q_high} + {1'b0, q_low};
   // high * 100 as shifted adds
   assign scaled_high = (REM_BITS'(q_high) << 6) + (REM_BITS'(q_high) << 5)
                      + (REM_BITS'(q_high) << 2);
   assign diff  = {1'b0, rem_ff} - {1'b0, dvs_ff};
   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign emit  = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         shown_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  if (q_ctl.edge_seen && sum != '0) begin
                     state_ff <= S_DIVIDE;
                  end else begin
                     state_ff <= S_EMIT;
                  end
               end
            end
            S_DIVIDE: begin
               if (step_ff == '0) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (emit) begin
                  state_ff <= S_IDLE;
                  shown_ff <= quot_ff;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // restoring division, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (q_pop) begin
         drive_ff <= q_ctl.motion;
         rem_ff   <= scaled_high;
         dvs_ff   <= REM_BITS'(sum) << (DUTY_BITS - 1);
         step_ff  <= STEP_BITS'(DUTY_BITS - 1);
         if (q_ctl.edge_seen) begin
            quot_ff <= '0;
         end else begin
            quot_ff <= shown_ff;
         end
      end else if (state_ff == S_DIVIDE) begin
         if (!diff[REM_BITS]) begin
            rem_ff  <= diff[REM_BITS-1:0];
            quot_ff <= {quot_ff[DUTY_BITS-2:0], 1'b1};
         end else begin
            quot_ff <= {quot_ff[DUTY_BITS-2:0], 1'b0};
         end
         dvs_ff  <= dvs_ff >> 1;
         step_ff <= step_ff - 1'b1;
      end
      if (emit) begin
         rsp_drive_ff   <= drive_ff;
         rsp_duty_ff    <= quot_ff;
         rsp_changed_ff <= quot_ff != shown_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_duty    = rsp_duty_ff;
   assign rsp_changed = rsp_changed_ff;

   `HBPM_ASSERT_IMPLIES(a_div_bound, clock, reset, state_ff == S_DIVIDE, (rem_ff >> 1) < dvs_ff)
   `HBPM_ASSERT_IMPLIES(a_duty_range, clock, reset, rsp_valid_ff, rsp_duty_ff <= DUTY_SCALE)

endmodule

>>> hdl/hbridge_channel_pwm_monitor_core.sv
`timescale 1ns / 1ps

// H-bridge channel monitor: every accepted event on req_ yields exactly one item
// on rsp_ carrying the decoded drive state, the enable duty cycle in whole
// percent (floor of high*100/(high+low), 0 for an empty period) and a flag
// that is set when the duty differs from the last reported one. An event whose
// enable level differs from the previous event is an edge and restarts the
// duty calculation; other events repeat the last duty. The front takes
// events, tracks edge stamps and spans and decodes the drive state in the
// same cycle, then queues a command (two entries deep). The back computes the
// duty with a restoring divider, one quotient bit per cycle: an edge event
// with a nonzero period goes through the pop, 7 divide steps and the output
// load on its way to rsp_; any other event goes from the pop straight to the
// output load. The back pops its next event only once the result is loaded.
// The divider sets the sustained rate; up to two events can wait in the queue
// while a result is held by the sink. csr_wdata written with csr_wen sets the
// pwm mode (reset 1); in jumper mode (0) the enable does not force free stop
// but the duty is still measured. No clearing pass after reset.
module hbridge_channel_pwm_monitor_core
   import hbpm_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic clock,
   input  logic reset,

   // configuration
   input  logic csr_wen,
   input  logic csr_wdata,                 // pwm_mode

   // event input
   input  logic req_tvalid,
   output logic req_tready,
   // event_time_ns, enable_level, dir_first, dir_second, zero pad
   input  logic [((TIME_BITS + 3 + 7) / 8) * 8 - 1:0] req_tdata,

   // result output
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // motion (drive state), duty_percent, duty_changed, zero pad
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int QDATA_BITS = 2 * TIME_BITS;

   // command between front and queue
   logic                 push;
   cmd_ctl_type          push_ctl;
   logic [TIME_BITS-1:0] push_high;
   logic [TIME_BITS-1:0] push_low;
   logic                 queue_full;

   // command between queue and back
   logic                  pop;
   logic                  not_empty;
   cmd_ctl_type           pop_ctl;
   logic [QDATA_BITS-1:0] pop_data;

   // result fields
   motion_type rsp_drive;
   duty_type   rsp_duty;
   logic       rsp_changed;

   hbpm_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_time       (req_tdata[TIME_BITS-1:0]),
      .in_enable     (req_tdata[TIME_BITS]),
      .in_dir_first  (req_tdata[TIME_BITS+1]),
      .in_dir_second (req_tdata[TIME_BITS+2]),
      .queue_full    (queue_full),
      .push          (push),
      .push_ctl      (push_ctl),
      .push_high     (push_high),
      .push_low      (push_low)
   );

   // high span in the upper half, low span in the lower half
   hbpm_queue #(
      .DATA_BITS (QDATA_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_ctl  (push_ctl),
      .push_data ({push_high, push_low}),
      .full      (queue_full),
      .not_empty (not_empty),
      .pop       (pop),
      .pop_ctl   (pop_ctl),
      .pop_data  (pop_data)
   );

   hbpm_back #(
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (not_empty),
      .q_ctl       (pop_ctl),
      .q_high      (pop_data[QDATA_BITS-1:TIME_BITS]),
      .q_low       (pop_data[TIME_BITS-1:0]),
      .q_pop       (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_drive   (rsp_drive),
      .rsp_duty    (rsp_duty),
      .rsp_changed (rsp_changed)
   );

   // pack result fields from the low bit up
   assign rsp_tdata = {{(RSP_DATA_BITS - RSP_FIELD_BITS){1'b0}}, rsp_changed, rsp_duty, rsp_drive};

endmodule
